// ===== hdl/sbct_pkg.sv =====
package sbct_pkg;

  localparam int LETTER_COUNT = 6;
  localparam int CODE_W       = 3;
  localparam int BOX_W        = 14;

  typedef logic [CODE_W-1:0]       code_t;
  typedef logic signed [BOX_W-1:0] box_val_t;

  function automatic logic code_ok(input code_t code);
    return code < CODE_W'(LETTER_COUNT);
  endfunction

  function automatic box_val_t box_aft(input code_t code);
    box_val_t v;
    unique case (code)
      3'd0:    v = -14'sd700;
      3'd1:    v = -14'sd1400;
      3'd2:    v = -14'sd2150;
      3'd3:    v = -14'sd3000;
      3'd4:    v = -14'sd3700;
      3'd5:    v = -14'sd4300;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic box_val_t box_fwd(input code_t code);
    box_val_t v;
    unique case (code)
      3'd0:    v = -14'sd50;
      3'd1:    v = -14'sd300;
      3'd2:    v = -14'sd950;
      3'd3:    v = -14'sd1300;
      3'd4:    v = -14'sd1600;
      3'd5:    v = -14'sd1900;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic box_val_t box_half(input code_t code);
    box_val_t v;
    unique case (code)
      3'd0:    v = 14'sd750;
      3'd1:    v = 14'sd1200;
      3'd2:    v = 14'sd1800;
      3'd3:    v = 14'sd2600;
      3'd4:    v = 14'sd3250;
      3'd5:    v = 14'sd4000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/segment_box_crossing_test.sv =====
// channel | ports        | tdata (low bit up)                      | tuser
// --------+--------------+-----------------------------------------+------------
// input   | in_t*        | start_x, start_y, end_x, end_y, pad     | letter_code
// output  | out_t*       | crossed, pad                            | -
//
// five register stages: edge distances, cross products, clip select,
// final products, output register; one beat per cycle in and out while
// out_tready holds high, and a new beat can enter each cycle unless
// the stages are full and the output is stalled.
// rst_n is synchronous and clears only the stage valid bits.
// each stage loads when it is empty or the one after it is empty or moving, so bubbles
// close up and input is taken while a result waits downstream.
module segment_box_crossing_test
  import sbct_pkg::*;
#(
  parameter int COORD_WIDTH = 20
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // start_x, start_y, end_x, end_y, zero pad
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]      in_tdata,
  // letter_code
  input  logic [CODE_W-1:0]                       in_tuser,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // crossed, zero pad
  output logic [7:0]                              out_tdata
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 2;
  localparam int PW = 2 * DW;

  typedef logic signed [DW-1:0] num_t;
  typedef logic signed [PW-1:0] prod_t;

  // stall chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5      = !v5_r || out_tready;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // stage 1: deltas and edge distances
  code_t    code;
  box_val_t aft, fwd, half;
  num_t     sx, sy, ex, ey, aft_e, fwd_e, half_e;
  num_t     dx, dy, q0, q1, q2, q3;
  logic     par_x, par_y;
  num_t     adx_nxt, ady_nxt, nex_nxt, ney_nxt, nlx_nxt, nly_nxt;
  logic     kill1_nxt;

  assign code   = in_tuser;
  assign aft    = box_aft(code);
  assign fwd    = box_fwd(code);
  assign half   = box_half(code);
  assign sx     = {{2{in_tdata[W-1]}},   in_tdata[W-1:0]};
  assign sy     = {{2{in_tdata[2*W-1]}}, in_tdata[2*W-1:W]};
  assign ex     = {{2{in_tdata[3*W-1]}}, in_tdata[3*W-1:2*W]};
  assign ey     = {{2{in_tdata[4*W-1]}}, in_tdata[4*W-1:3*W]};
  assign aft_e  = {{(DW-BOX_W){aft[BOX_W-1]}},  aft};
  assign fwd_e  = {{(DW-BOX_W){fwd[BOX_W-1]}},  fwd};
  assign half_e = {{(DW-BOX_W){half[BOX_W-1]}}, half};

  always_comb begin
    dx = ex - sx;
    dy = ey - sy;
    q0 = sx - aft_e;
    q1 = fwd_e - sx;
    q2 = sy + half_e;
    q3 = half_e - sy;
    par_x = (dx == '0) && (q0 < 0 || q1 < 0);
    par_y = (dy == '0) && (q2 < 0 || q3 < 0);
    adx_nxt = (dx < 0) ? -dx : dx;
    ady_nxt = (dy < 0) ? -dy : dy;
    nex_nxt = (dx > 0) ? -q0 : -q1;
    nlx_nxt = (dx > 0) ? q1 : q0;
    ney_nxt = (dy > 0) ? -q2 : -q3;
    nly_nxt = (dy > 0) ? q3 : q2;
    kill1_nxt = !code_ok(code) || par_x || par_y;
  end

  num_t adx1_r, ady1_r, nex1_r, ney1_r, nlx1_r, nly1_r;
  logic kill1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      adx1_r  <= adx_nxt;
      ady1_r  <= ady_nxt;
      nex1_r  <= nex_nxt;
      ney1_r  <= ney_nxt;
      nlx1_r  <= nlx_nxt;
      nly1_r  <= nly_nxt;
      kill1_r <= kill1_nxt;
    end
  end

  // stage 2: cross products between axes, clamp flags
  prod_t pex2_r, pey2_r, plx2_r, ply2_r;
  num_t  adx2_r, ady2_r, nex2_r, ney2_r, nlx2_r, nly2_r;
  logic  xgt2_r, ygt2_r, xlt2_r, ylt2_r, kill2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      pex2_r  <= PW'(nex1_r) * PW'(ady1_r);
      pey2_r  <= PW'(ney1_r) * PW'(adx1_r);
      plx2_r  <= PW'(nlx1_r) * PW'(ady1_r);
      ply2_r  <= PW'(nly1_r) * PW'(adx1_r);
      xgt2_r  <= nex1_r > 0;
      ygt2_r  <= ney1_r > 0;
      xlt2_r  <= nlx1_r < adx1_r;
      ylt2_r  <= nly1_r < ady1_r;
      adx2_r  <= adx1_r;
      ady2_r  <= ady1_r;
      nex2_r  <= nex1_r;
      ney2_r  <= ney1_r;
      nlx2_r  <= nlx1_r;
      nly2_r  <= nly1_r;
      kill2_r <= kill1_r;
    end
  end

  // stage 3: latest entry, earliest exit
  logic ax, ay, en_take_x, lv_take_x, en_has, lv_has, en_gt, lv_lt;
  num_t en_n_nxt, en_d_nxt, lv_n_nxt, lv_d_nxt;

  always_comb begin
    ax = adx2_r != '0;
    ay = ady2_r != '0;
    en_take_x = ax && (!ay || pex2_r > pey2_r);
    lv_take_x = ax && (!ay || plx2_r < ply2_r);
    en_has    = ax || ay;
    lv_has    = ax || ay;
    en_gt     = en_take_x ? xgt2_r : ygt2_r;
    lv_lt     = lv_take_x ? xlt2_r : ylt2_r;
    if (en_has && en_gt) begin
      en_n_nxt = en_take_x ? nex2_r : ney2_r;
      en_d_nxt = en_take_x ? adx2_r : ady2_r;
    end else begin
      en_n_nxt = '0;
      en_d_nxt = DW'(1);
    end
    if (lv_has && lv_lt) begin
      lv_n_nxt = lv_take_x ? nlx2_r : nly2_r;
      lv_d_nxt = lv_take_x ? adx2_r : ady2_r;
    end else begin
      lv_n_nxt = DW'(1);
      lv_d_nxt = DW'(1);
    end
  end

  num_t en_n3_r, en_d3_r, lv_n3_r, lv_d3_r;
  logic kill3_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      en_n3_r <= en_n_nxt;
      en_d3_r <= en_d_nxt;
      lv_n3_r <= lv_n_nxt;
      lv_d3_r <= lv_d_nxt;
      kill3_r <= kill2_r;
    end
  end

  // stage 4: exit vs entry products
  prod_t f_lv4_r, f_en4_r;
  logic  kill4_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      f_lv4_r <= PW'(lv_n3_r) * PW'(en_d3_r);
      f_en4_r <= PW'(en_n3_r) * PW'(lv_d3_r);
      kill4_r <= kill3_r;
    end
  end

  // stage 5: output register
  logic crossed5_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      crossed5_r <= !kill4_r && (f_lv4_r > f_en4_r);
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {7'd0, crossed5_r};

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sbct_pkg::*;

  localparam int CW = 20;
  localparam int DATA_W = ((4*CW+7)/8)*8;
  localparam int HOLD_CYCLES = 120;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  localparam code_t LETTER_A = code_t'(0);
  localparam code_t LETTER_B = code_t'(1);
  localparam code_t LETTER_C = code_t'(2);
  localparam code_t LETTER_D = code_t'(3);
  localparam code_t LETTER_E = code_t'(4);
  localparam code_t LETTER_F = code_t'(5);
  localparam code_t NO_BOX_6 = code_t'(6);
  localparam code_t NO_BOX_7 = code_t'(7);

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    code_t  code;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   crossed;
  } crossing_t;

  localparam int COORD_MIN = -(2**(CW-1));
  localparam int COORD_MAX = 2**(CW-1) - 1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic [CODE_W-1:0] in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;

  crossing_t pending_crossings[$];
  int        errors = 0;
  bit        tx_idle = 1'b0;
  bit        rx_idle = 1'b0;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  int        gap_left = 0;
  int        stuck_cycles = 0;

  segment_box_crossing_test #(
    .COORD_WIDTH(CW)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // keep-out box of each letter, zero box for codes with no letter
  function automatic void box_edges(input code_t code, output longint aft,
                                    output longint fwd, output longint half);
    case (code)
      LETTER_A: begin aft = -700;  fwd = -50;   half = 750;  end
      LETTER_B: begin aft = -1400; fwd = -300;  half = 1200; end
      LETTER_C: begin aft = -2150; fwd = -950;  half = 1800; end
      LETTER_D: begin aft = -3000; fwd = -1300; half = 2600; end
      LETTER_E: begin aft = -3700; fwd = -1600; half = 3250; end
      LETTER_F: begin aft = -4300; fwd = -1900; half = 4000; end
      default: begin aft = 0; fwd = 0; half = 0; end
    endcase
  endfunction

  // clip the segment against the box, entry and exit kept as exact fractions
  function automatic logic segment_crosses_box(input code_t code, input coord_t sx,
                                               input coord_t sy, input coord_t ex,
                                               input coord_t ey);
    longint aft, fwd, half, dx, dy, num, den;
    longint dir[4];
    longint bound_dist[4];
    longint enter_n, enter_d, leave_n, leave_d;
    if (code >= code_t'(LETTER_COUNT))
      return 1'b0;
    box_edges(code, aft, fwd, half);
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    dir[0] = -dx; bound_dist[0] = longint'(sx) - aft;
    dir[1] = dx;  bound_dist[1] = fwd - longint'(sx);
    dir[2] = -dy; bound_dist[2] = longint'(sy) + half;
    dir[3] = dy;  bound_dist[3] = half - longint'(sy);
    enter_n = 0; enter_d = 1;
    leave_n = 1; leave_d = 1;
    for (int k = 0; k < 4; k++) begin
      if (dir[k] == 0) begin
        if (bound_dist[k] < 0)
          return 1'b0;
      end else if (dir[k] < 0) begin
        num = -bound_dist[k];
        den = -dir[k];
        if (num * enter_d > enter_n * den) begin
          enter_n = num;
          enter_d = den;
        end
      end else begin
        num = bound_dist[k];
        den = dir[k];
        if (num * leave_d < leave_n * den) begin
          leave_n = num;
          leave_d = den;
        end
      end
    end
    return (leave_n * enter_d > enter_n * leave_d);
  endfunction

  // record each accepted query, then check each result beat
  always @(posedge clk) begin
    crossing_t q;
    crossing_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        q.code = in_tuser;
        q.sx = in_tdata[0*CW +: CW];
        q.sy = in_tdata[1*CW +: CW];
        q.ex = in_tdata[2*CW +: CW];
        q.ey = in_tdata[3*CW +: CW];
        q.crossed = segment_crosses_box(q.code, q.sx, q.sy, q.ex, q.ey);
        pending_crossings.push_back(q);
      end
      if (out_tvalid && out_tready) begin
        if (pending_crossings.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual crossed %0b",
                   $time, out_tdata[0]);
        end else begin
          want = pending_crossings.pop_front();
          if (out_tdata[0] !== want.crossed) begin
            errors++;
            $display("%0t: crossed mismatch letter %0d (%0d,%0d)->(%0d,%0d) expected %0b actual %0b",
                     $time, want.code, want.sx, want.sy, want.ex, want.ey,
                     want.crossed, out_tdata[0]);
          end
        end
      end
    end
  end

  // receiver: long hold on request, random stall bursts when enabled
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      out_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 3) == 0) begin
      gap_left = $urandom_range(1, 7) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_segment(input code_t code, input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ey, ex, sy, sx};
    in_tuser <= code;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // directed beat from integer coordinates
  task automatic send_at(input code_t code, input int sx, input int sy,
                         input int ex, input int ey);
    send_segment(code, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
  endtask

  function automatic coord_t coord_near(input longint lo, input longint hi);
    longint v;
    v = lo - 400 + longint'($urandom_range(0, int'(hi - lo + 800)));
    return coord_t'(v);
  endfunction

  function automatic coord_t coord_on_edge(input longint lo, input longint hi);
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0)
      return coord_t'(lo);
    else if (pick == 1)
      return coord_t'(hi);
    return coord_near(lo, hi);
  endfunction

  task automatic random_segment(output code_t code, output coord_t sx, output coord_t sy,
                                output coord_t ex, output coord_t ey);
    int pick;
    int mode;
    longint aft, fwd, half;
    pick = $urandom_range(0, 19);
    if (pick < 18)
      code = code_t'(pick % LETTER_COUNT);
    else
      code = code_t'($urandom_range(LETTER_COUNT, 2**CODE_W - 1));
    box_edges(code, aft, fwd, half);
    sx = coord_near(aft, fwd);
    sy = coord_near(-half, half);
    ex = coord_near(aft, fwd);
    ey = coord_near(-half, half);
    mode = $urandom_range(0, 9);
    case (mode)
      5: begin
        sx = coord_on_edge(aft, fwd);
        sy = coord_on_edge(-half, half);
        ex = coord_on_edge(aft, fwd);
        ey = coord_on_edge(-half, half);
      end
      6: begin
        if ($urandom_range(0, 1))
          ex = sx;
        else
          ey = sy;
      end
      7: begin
        if ($urandom_range(0, 1)) begin
          sx = coord_on_edge(aft, fwd);
          sy = coord_on_edge(-half, half);
        end
        ex = sx;
        ey = sy;
      end
      8: begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
      end
      9: begin
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
      end
      default: ;
    endcase
  endtask

  task automatic send_random_segments(input int count);
    code_t  code;
    coord_t sx, sy, ex, ey;
    repeat (count) begin
      random_segment(code, sx, sy, ex, ey);
      send_segment(code, sx, sy, ex, ey);
    end
  endtask

  task automatic test_directed();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_at(LETTER_A, -600, -100, -100, 100);
    send_at(LETTER_A, 0, 0, 100, 100);
    send_at(LETTER_A, -1000, 0, 500, 0);
    // parallel to an edge, outside of it
    send_at(LETTER_A, -400, 800, -200, 800);
    send_at(LETTER_A, -800, -100, -800, 100);
    // single-point touches at a corner, and a miss just beside one
    send_at(LETTER_A, -50, 750, 100, 900);
    send_at(LETTER_A, -100, 800, 0, 700);
    send_at(LETTER_B, -1500, 1200, -1400, 1300);
    // lying along an edge
    send_at(LETTER_A, -700, -200, -700, 300);
    send_at(LETTER_A, -600, 750, -100, 750);
    send_at(LETTER_F, -1900, -5000, -1900, 5000);
    // zero length inside, on the boundary, outside
    send_at(LETTER_A, -300, 0, -300, 0);
    send_at(LETTER_A, -50, 750, -50, 750);
    send_at(LETTER_A, 0, 0, 0, 0);
    // codes naming no box
    send_at(NO_BOX_6, -600, 0, -100, 0);
    send_at(NO_BOX_7, COORD_MIN, 0, COORD_MAX, 0);
    send_at(LETTER_A, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_at(LETTER_F, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_at(LETTER_F, COORD_MIN, 0, COORD_MAX, 0);
    send_at(LETTER_E, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_at(LETTER_D, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_at(LETTER_B, -1400, -1200, -300, 1200);
    send_at(LETTER_C, -2150, 1800, -950, -1800);
    send_at(LETTER_D, -3500, 0, -800, 0);
    send_at(LETTER_E, -2650, -4000, -2650, 4000);
  endtask

  task automatic test_random_with_idling();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_random_segments(1400);
  endtask

  task automatic test_receiver_hold();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    send_random_segments(150);
  endtask

  task automatic test_back_to_back();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_random_segments(320);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_with_idling();
    test_receiver_hold();
    test_back_to_back();
    in_tvalid <= 1'b0;
    while (pending_crossings.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
